### rtl/cs_pkg.sv
`timescale 1ns / 1ps

package cs_pkg;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    // what one input transfer leaves for the output side
    typedef struct packed {
        logic [7:0] byte1;  // second kept byte, only when two is set
        logic       two;    // two results
        logic [7:0] byte0;  // first result data
        logic       valid0; // first result carries a kept byte
        logic       last;   // end of text on the final result
    } cs_rec_t;

    typedef struct packed {
        logic    valid;
        cs_rec_t rec;
    } cs_head_t;

endpackage

### rtl/comment_stripper.sv
`timescale 1ns / 1ps

// Removes C-style comments from a byte stream. Each byte comes in as one
// s_axis transfer with tlast on the final byte of a text; each kept byte leaves
// as one m_axis transfer with tuser high. The block holds one byte back to see
// the byte after it, so a byte is sent once its successor (or tlast) arrives.
// Line comments run from slash slash to a newline, which is kept; block comments
// nest to a saturating depth of DEPTH_BITS bits; double quotes outside comments
// toggle string mode, where every byte is kept. When neither the held byte nor
// the final byte is kept, a single transfer with tuser low, tdata zero and tlast
// high marks the end. The input side takes one byte per cycle while the record
// queue has room; the output side sends one result per cycle while m_axis_tready
// is high, so an input byte that releases two results (held byte plus final
// byte) sends them as two transfers, absorbed by a four-entry record queue
// between the classifier and the output sequencer.
module comment_stripper
    import cs_pkg::*;
#(
    parameter int DEPTH_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tuser,  // [0] out_valid
    output logic       m_axis_tlast
);

    logic     in_fire;
    logic     push;
    logic     pop;
    logic     has_room;
    cs_rec_t  push_rec;
    cs_head_t head;

    assign s_axis_tready = has_room;
    assign in_fire       = s_axis_tvalid && has_room;

    cs_front #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .push    (push),
        .push_rec(push_rec)
    );

    cs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_rec(push_rec),
        .has_room(has_room),
        .pop     (pop),
        .head    (head)
    );

    cs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_axis_tvalid),
        .m_tready(m_axis_tready),
        .m_tdata (m_axis_tdata),
        .m_tuser (m_axis_tuser),
        .m_tlast (m_axis_tlast)
    );

endmodule

### rtl/cs_front.sv
`timescale 1ns / 1ps

module cs_front
    import cs_pkg::*;
#(
    parameter int DEPTH_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output cs_rec_t    push_rec
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    typedef struct packed {
        logic                  keep;
        logic                  consumed;
        logic                  str;
        logic                  line;
        logic [DEPTH_BITS-1:0] depth;
    } judge_t;

    function automatic judge_t judge(
        input logic [7:0]            c,
        input logic                  has_next,
        input logic [7:0]            nxt,
        input logic                  str,
        input logic                  line,
        input logic [DEPTH_BITS-1:0] depth
    );
        judge_t r;
        logic   in_block;
        logic   line_after;
        in_block   = (depth != '0);
        r.keep     = 1'b0;
        r.consumed = 1'b0;
        r.str      = str;
        r.line     = line;
        r.depth    = depth;
        line_after = line;
        if (!in_block && !line && c == CH_QUOTE) begin
            r.str  = !str;
            r.keep = 1'b1;
        end else if (str) begin
            r.keep = 1'b1;
        end else if (!in_block && !line && c == CH_SLASH && has_next && nxt == CH_SLASH) begin
            r.line = 1'b1;
        end else if (!line && c == CH_SLASH && has_next && nxt == CH_STAR) begin
            if (depth != DEPTH_MAX) begin
                r.depth = depth + DEPTH_ONE;
            end
            r.consumed = 1'b1;
        end else if (in_block && c == CH_STAR && has_next && nxt == CH_SLASH) begin
            r.depth    = depth - DEPTH_ONE;
            r.consumed = 1'b1;
        end else begin
            if (line && c == CH_NEWLINE) begin
                line_after = 1'b0;
            end
            r.line = line_after;
            r.keep = !in_block && !line_after;
        end
        return r;
    endfunction

    logic [7:0]            held_byte_reg, held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  str_reg, str_next;
    logic                  line_reg, line_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;

    judge_t j_held, j_new;
    logic   keep0, keep1, pending;
    logic                  str_mid, line_mid;
    logic [DEPTH_BITS-1:0] depth_mid;

    always_comb begin
        j_held    = judge(held_byte_reg, 1'b1, in_byte, str_reg, line_reg, depth_reg);
        str_mid   = held_valid_reg ? j_held.str   : str_reg;
        line_mid  = held_valid_reg ? j_held.line  : line_reg;
        depth_mid = held_valid_reg ? j_held.depth : depth_reg;
        pending   = !(held_valid_reg && j_held.consumed);
        // last byte is judged with no lookahead
        j_new     = judge(in_byte, 1'b0, 8'h00, str_mid, line_mid, depth_mid);
        keep0     = held_valid_reg && j_held.keep;
        keep1     = pending && in_last && j_new.keep;

        push_rec.byte1  = in_byte;
        push_rec.two    = keep0 && keep1;
        push_rec.byte0  = keep0 ? held_byte_reg : (keep1 ? in_byte : 8'h00);
        push_rec.valid0 = keep0 || keep1;
        push_rec.last   = in_last;
        push            = in_fire && (keep0 || keep1 || in_last);

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        str_next        = str_reg;
        line_next       = line_reg;
        depth_next      = depth_reg;
        if (in_fire) begin
            if (in_last) begin
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                str_next        = 1'b0;
                line_next       = 1'b0;
                depth_next      = '0;
            end else begin
                held_byte_next  = in_byte;
                held_valid_next = pending;
                str_next        = str_mid;
                line_next       = line_mid;
                depth_next      = depth_mid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            str_reg        <= 1'b0;
            line_reg       <= 1'b0;
            depth_reg      <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            str_reg        <= str_next;
            line_reg       <= line_next;
            depth_reg      <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_byte_reg <= held_byte_next;
    end

endmodule

### rtl/cs_queue.sv
`timescale 1ns / 1ps

module cs_queue
    import cs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  cs_rec_t  push_rec,
    output logic     has_room,
    input  logic     pop,
    output cs_head_t head
);

    cs_rec_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;
    logic                  do_push, do_pop;

    always_comb begin
        has_room    = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
        head.valid  = (count_reg != '0);
        head.rec    = mem_reg[rd_ptr_reg];
        do_push     = push && has_room;
        do_pop      = pop && head.valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

### rtl/cs_back.sv
`timescale 1ns / 1ps

module cs_back
    import cs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cs_head_t   head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser,
    output logic       m_tlast
);

    // set while the second result of a record is on the port
    logic second_reg, second_next;
    logic fire;

    always_comb begin
        m_tvalid = head.valid;
        fire     = head.valid && m_tready;
        if (second_reg) begin
            m_tdata = head.rec.byte1;
            m_tuser = 1'b1;
            m_tlast = head.rec.last;
        end else begin
            m_tdata = head.rec.byte0;
            m_tuser = head.rec.valid0;
            m_tlast = head.rec.last && !head.rec.two;
        end
        pop         = fire && (!head.rec.two || second_reg);
        second_next = second_reg;
        if (fire) begin
            second_next = head.rec.two && !second_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else begin
            second_reg <= second_next;
        end
    end

endmodule

### rtl/cs_checker.sv
`timescale 1ns / 1ps

module cs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // nothing comes out right after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output transfer offered right after reset");

    // an empty result only ever marks the end of a text
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'h00)
        else $error("empty result without end marker");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("m_axis payload changed while stalled");

endmodule

bind comment_stripper cs_checker u_cs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);
